@@ sv/cfe_pkg.sv @@
// Shared types and constants for the COBS frame encoder.
// No dependencies; imported by every other file of the block.
package cfe_pkg;

  localparam int MAX_MESSAGE_BYTES = 62;
  localparam int CODE_W = 7;
  localparam int IDX_W = 6;

  localparam logic [CODE_W-1:0] CODE_EMPTY = 7'h01;
  localparam logic [CODE_W-1:0] CODE_FULL = 7'(MAX_MESSAGE_BYTES + 1);
  localparam logic [7:0] DELIM_BYTE = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CODE,
    ST_DATA,
    ST_DELIM
  } state_e;

  typedef struct packed {
    logic capture;
    logic load_code;
    logic load_data;
    logic load_delim;
    logic end_flush;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic zero_in;
    logic last_in;
    logic code_one;
    logic data_last;
    logic out_free;
    logic extra;
    logic last_q;
  } status_t;

endpackage

@@ sv/cfe_datapath.sv @@
// Datapath of the COBS frame encoder: group buffer, group code, read index,
// pending flags and the output register. Depends on cfe_pkg.
module cfe_datapath import cfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output out_t    out_data_o
);

  logic [7:0]        mem_q [MAX_MESSAGE_BYTES];
  logic [7:0]        rd_data_q;
  logic [CODE_W-1:0] code_q, code_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              last_q, last_d;
  logic              extra_q, extra_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic [CODE_W-1:0] count;
  logic [CODE_W-1:0] idx_next;
  logic              full;
  logic              zero_in;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  assign full     = code_q >= CODE_FULL;
  assign zero_in  = in_data_i.data_byte == 8'h00;
  assign count    = code_q - CODE_EMPTY;
  assign idx_next = {1'b0, idx_q} + 7'd1;
  assign wr_en    = cmd_i.capture && !full && !zero_in;
  assign wr_addr  = count[IDX_W-1:0];

  always_comb begin
    code_d      = code_q;
    idx_d       = idx_q;
    last_d      = last_q;
    extra_d     = extra_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.capture) begin
      last_d  = in_data_i.last_byte;
      extra_d = in_data_i.last_byte && zero_in && !full;
      if (wr_en) begin
        code_d = code_q + 7'd1;
      end
    end
    if (cmd_i.load_code) begin
      out_d       = '{out_byte: {1'b0, code_q}, frame_end: 1'b0};
      out_valid_d = 1'b1;
    end
    if (cmd_i.load_data) begin
      out_d       = '{out_byte: rd_data_q, frame_end: 1'b0};
      out_valid_d = 1'b1;
      idx_d       = idx_next[IDX_W-1:0];
    end
    if (cmd_i.load_delim) begin
      out_d       = '{out_byte: DELIM_BYTE, frame_end: 1'b1};
      out_valid_d = 1'b1;
    end
    if (cmd_i.end_flush) begin
      code_d  = CODE_EMPTY;
      idx_d   = '0;
      extra_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q      <= CODE_EMPTY;
      idx_q       <= '0;
      last_q      <= 1'b0;
      extra_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      code_q      <= code_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      extra_q     <= extra_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_data_i.data_byte;
    end
    rd_data_q <= mem_q[idx_d];
  end

  assign status_o = '{
    full:      full,
    zero_in:   zero_in,
    last_in:   in_data_i.last_byte,
    code_one:  code_q == CODE_EMPTY,
    data_last: idx_next == count,
    out_free:  !out_valid_q || !out_stall_i,
    extra:     extra_q,
    last_q:    last_q
  };

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/cfe_ctrl.sv @@
// Controller of the COBS frame encoder: sequences capture, group flushes
// and the closing delimiter. Depends on cfe_pkg.
module cfe_ctrl import cfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = state_q != ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if ((!status_i.full && status_i.zero_in) || status_i.last_in) begin
            state_d = ST_CODE;
          end
        end
      end
      ST_CODE: begin
        if (status_i.out_free) begin
          cmd_o.load_code = 1'b1;
          if (status_i.code_one) begin
            cmd_o.end_flush = 1'b1;
            if (status_i.extra) begin
              state_d = ST_CODE;
            end else if (status_i.last_q) begin
              state_d = ST_DELIM;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (status_i.out_free) begin
          cmd_o.load_data = 1'b1;
          if (status_i.data_last) begin
            cmd_o.end_flush = 1'b1;
            if (status_i.extra) begin
              state_d = ST_CODE;
            end else if (status_i.last_q) begin
              state_d = ST_DELIM;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_DELIM: begin
        if (status_i.out_free) begin
          cmd_o.load_delim = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/cobs_frame_encoder.sv @@
// Top level of the COBS frame encoder: controller plus datapath.
// Depends on cfe_pkg, cfe_ctrl and cfe_datapath.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  in_data_i  (in_t)
//   out      source     out_valid_o / out_stall_i out_data_o (out_t)
//
// A byte that is only buffered is taken with its request alone.
// A byte that closes a group is followed by the code byte, the data bytes
// and, at frame end, the delimiter, one output byte per cycle from the
// output register while out_stall_i is low.
// Reset returns the group code to one; the buffer itself is not cleared.
// Output stalls hold the controller; input is stalled until the group is sent.
module cobs_frame_encoder import cfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  cfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cfe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for the COBS frame encoder: random and directed frames are
// stuffed by a local predictor and each encoded byte is checked in order.
// Depends on cfe_pkg and cobs_frame_encoder.
module testbench;
  import cfe_pkg::*;

  class frame_stuffer;
    logic [7:0]        group_bytes [MAX_MESSAGE_BYTES];
    logic [CODE_W-1:0] code;
    out_t              pending_bytes [$];
    int                errors;

    function new();
      code   = CODE_EMPTY;
      errors = 0;
    endfunction

    function void emit(logic [7:0] value, logic frame_end);
      out_t item;
      item.out_byte  = value;
      item.frame_end = frame_end;
      pending_bytes.push_back(item);
    endfunction

    function void close_group();
      emit({1'b0, code}, 1'b0);
      for (int i = 0; i < int'(code) - 1; i++) emit(group_bytes[i], 1'b0);
      code = CODE_EMPTY;
    endfunction

    function void take_request(in_t req);
      if (code < CODE_FULL) begin
        if (req.data_byte == 8'h00) begin
          close_group();
        end else begin
          group_bytes[int'(code) - 1] = req.data_byte;
          code = code + 1'b1;
        end
      end
      if (req.last_byte) begin
        close_group();
        emit(DELIM_BYTE, 1'b1);
      end
    endfunction

    function void check_byte(out_t got);
      out_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected output: out_byte %h frame_end %b", got.out_byte, got.frame_end);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;

  frame_stuffer stuffer = new();

  in_t directed_items [17] = '{
    {8'hFF, 1'b1},
    {8'h00, 1'b1},
    {8'h01, 1'b0}, {8'h00, 1'b0}, {8'h80, 1'b0}, {8'h00, 1'b1},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h7F, 1'b1},
    {8'hAA, 1'b0}, {8'h55, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0},
    {8'hFE, 1'b1},
    {8'h0F, 1'b0}, {8'hF0, 1'b1}
  };

  cobs_frame_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) stuffer.check_byte(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic push_byte(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    stuffer.take_request(req);
  endtask

  task automatic send_message(input int len, input int zero_pct, input int solid);
    in_t req;
    for (int i = 0; i < len; i++) begin
      if (i >= solid && $urandom_range(99) < zero_pct) req.data_byte = 8'h00;
      else req.data_byte = 8'($urandom_range(1, 255));
      req.last_byte = (i == len - 1);
      push_byte(req);
    end
    items_sent += len;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_items[i]) push_byte(directed_items[i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 22 : (phase == 1) ? 72 : 0;
      recv_stall_pct = (phase == 0) ? 72 : (phase == 1) ? 22 : 0;
      if (phase == 1) send_message(MAX_MESSAGE_BYTES, 0, MAX_MESSAGE_BYTES);
      if (phase == 2) send_message(MAX_MESSAGE_BYTES + $urandom_range(3, 8), 40,
                                   MAX_MESSAGE_BYTES);
      items_sent = 0;
      while (items_sent < 24) send_message($urandom_range(1, 12), $urandom_range(0, 60), 0);
    end

    in_valid_i <= 1'b0;
    while (stuffer.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (stuffer.errors == 0 && stuffer.pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
